// File: rtl/u8d_pkg.sv
// Shared types, constants and decode functions for the UTF-8 decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int OFFSET_BITS = 32;   // width of the saturating UTF-16 offset counter
    localparam int CP_W        = 21;
    localparam int WIN_N       = 4;    // held bytes plus the new one

    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hbf;
    localparam logic [7:0] LEAD2_LO   = 8'hc2;
    localparam logic [7:0] LEAD2_HI   = 8'hdf;
    localparam logic [7:0] LEAD_E0    = 8'he0;
    localparam logic [7:0] LEAD_ED    = 8'hed;
    localparam logic [7:0] LEAD3_HI   = 8'hef;
    localparam logic [7:0] LEAD_F0    = 8'hf0;
    localparam logic [7:0] LEAD_F4    = 8'hf4;
    localparam logic [7:0] E0_SEC_LO  = 8'ha0;
    localparam logic [7:0] ED_SEC_HI  = 8'h9f;
    localparam logic [7:0] F0_SEC_LO  = 8'h90;
    localparam logic [7:0] F4_SEC_HI  = 8'h8f;
    localparam logic [CP_W-1:0] BMP_MAX = 21'h00ffff;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef logic [WIN_N-1:0][7:0] t_window;

    typedef struct packed {
        logic            emit;
        logic [2:0]      len;
        logic [CP_W-1:0] cp;
    } t_eval;

    // controller -> datapath
    typedef struct packed {
        logic load;    // take the input beat into the window
        logic emit;    // issue one result and retire its bytes
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic can_emit;   // window yields a result now
        logic more;       // window after this result yields another
        logic out_free;   // output register can take a result
    } t_status;

    function automatic logic f_is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Examine the window: does it yield a result, how many bytes, which scalar.
    function automatic t_eval f_eval(input t_window w, input logic [2:0] n, input logic last);
        t_eval      r;
        logic [7:0] b0;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [2:0] need;
        logic [2:0] avail;
        logic       ok;
        logic       incomplete;
        b0   = w[0];
        lo   = CONT_LO;
        hi   = CONT_HI;
        need = 3'd1;
        if (b0 >= LEAD2_LO && b0 <= LEAD2_HI) begin
            need = 3'd2;
        end else if (b0 == LEAD_E0) begin
            lo   = E0_SEC_LO;
            need = 3'd3;
        end else if (b0 == LEAD_ED) begin
            hi   = ED_SEC_HI;
            need = 3'd3;
        end else if (b0 > LEAD_E0 && b0 <= LEAD3_HI) begin
            need = 3'd3;
        end else if (b0 == LEAD_F0) begin
            lo   = F0_SEC_LO;
            need = 3'd4;
        end else if (b0 == LEAD_F4) begin
            hi   = F4_SEC_HI;
            need = 3'd4;
        end else if (b0 > LEAD_F0 && b0 < LEAD_F4) begin
            need = 3'd4;
        end
        avail = (n < need) ? n : need;
        ok = 1'b1;
        if (avail > 3'd1 && (w[1] < lo || w[1] > hi)) ok = 1'b0;
        if (avail > 3'd2 && !f_is_cont(w[2])) ok = 1'b0;
        if (avail > 3'd3 && !f_is_cont(w[3])) ok = 1'b0;
        incomplete = ok && (n < need);
        r.emit = (n != 3'd0) && !(incomplete && !last);
        r.len  = (ok && !incomplete) ? need : 3'd1;
        case (r.len)
            3'd2:    r.cp = {10'd0, w[0][4:0], w[1][5:0]};
            3'd3:    r.cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
            3'd4:    r.cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
            default: r.cp = {13'd0, w[0]};
        endcase
        return r;
    endfunction

    function automatic t_window f_shift(input t_window w, input logic [2:0] len);
        t_window r;
        case (len)
            3'd1:    r = {8'd0, w[3:1]};
            3'd2:    r = {16'd0, w[3:2]};
            3'd3:    r = {24'd0, w[3]};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic f_trim_space(input logic [CP_W-1:0] c);
        return c == 21'h09 || c == 21'h0a || c == 21'h0b || c == 21'h0c || c == 21'h0d ||
               c == 21'h20 || c == 21'ha0 || c == 21'h1680 ||
               (c >= 21'h2000 && c <= 21'h200a) || c == 21'h2028 || c == 21'h2029 ||
               c == 21'h202f || c == 21'h205f || c == 21'h3000 || c == 21'hfeff;
    endfunction

endpackage

`default_nettype wire

// File: rtl/u8d_ctrl.sv
// Step sequencer of the UTF-8 decoder: accepts a byte, then issues results.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  u8d_pkg::t_status i_status,
    output u8d_pkg::t_cmd    o_cmd
);
    import u8d_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_status.can_emit) begin
                    // unfinished sequence stays held for the next beat
                    n_state    = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.more) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/u8d_datapath.sv
// Byte window, UTF-16 offset counter and result register of the UTF-8 decoder.
// Depends on u8d_pkg; driven by u8d_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module u8d_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [7:0]                   i_byte,
    input  wire                          i_last,
    input  u8d_pkg::t_cmd                i_cmd,
    output u8d_pkg::t_status             o_status,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [u8d_pkg::CP_W-1:0]     o_scalar,
    output logic [2:0]                   o_byte_count,
    output logic [1:0]                   o_utf16_units,
    output logic [31:0]                  o_unit_offset,
    output logic                         o_trim_space,
    output logic                         o_run_last,
    output logic                         o_string_end
);
    import u8d_pkg::*;

    t_window                r_win;
    logic [2:0]             r_cnt;       // bytes in window, 0..4
    logic                   r_last;
    logic [OFFSET_BITS-1:0] r_units;
    logic [OFFSET_BITS-1:0] n_units;
    logic                   r_out_valid;

    t_eval                  w_cur;
    t_eval                  w_nxt;
    t_window                w_rest;
    logic [2:0]             w_rest_cnt;
    logic [1:0]             w_units;
    logic [OFFSET_BITS:0]   w_sum;
    logic [63:0]            w_off_ext;

    assign w_cur      = f_eval(r_win, r_cnt, r_last);
    assign w_rest     = f_shift(r_win, w_cur.len);
    assign w_rest_cnt = r_cnt - w_cur.len;
    assign w_nxt      = f_eval(w_rest, w_rest_cnt, r_last);
    assign w_units    = (w_cur.cp > BMP_MAX) ? 2'd2 : 2'd1;

    assign w_sum   = {1'b0, r_units} + (OFFSET_BITS + 1)'(w_units);
    assign n_units = w_sum[OFFSET_BITS] ? '1 : w_sum[OFFSET_BITS-1:0];

    assign w_off_ext = 64'(r_units);

    assign o_status.can_emit = w_cur.emit;
    assign o_status.more     = w_nxt.emit;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 3'd0;
            r_units     <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt  <= r_cnt + 3'd1;
                r_last <= i_last;
            end else if (i_cmd.emit) begin
                r_cnt <= w_rest_cnt;
                // string done: offset starts over for the next one
                r_units <= (r_last && !w_nxt.emit) ? '0 : n_units;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[r_cnt[1:0]] <= i_byte;
        end else if (i_cmd.emit) begin
            r_win <= w_rest;
        end
        if (i_cmd.emit) begin
            o_scalar      <= w_cur.cp;
            o_byte_count  <= w_cur.len;
            o_utf16_units <= w_units;
            o_unit_offset <= (|w_off_ext[63:32]) ? 32'hffff_ffff : w_off_ext[31:0];
            o_trim_space  <= f_trim_space(w_cur.cp);
            o_run_last    <= !w_nxt.emit;
            o_string_end  <= !w_nxt.emit && r_last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/utf8_decoder_with_utf16_count.sv
// UTF-8 decoder with UTF-16 offset tracking: streaming top level.
// Usage:
//  - Input stream: one byte per beat in s_axis tdata[7:0]; tlast marks the final
//    byte of a string and flushes every held byte.
//  - Output stream: one beat per decoded code point (or raw lead byte of a bad
//    or truncated sequence). tuser[1] marks the last result caused by an input
//    byte, tlast the last result of the string.
//  - An input byte is taken into the window; the sequencer then issues the
//    results it releases (0 to 4 per byte, set by the single decode/shift
//    stage), one after another, and goes back to taking input after the last
//    of them, or straight away if the byte is only held.
//  - Byte is held in the window register, its results go to the output register.
//  - Input ready drops while a byte's results are being issued.
//  - If the receiver stalls, the result register holds and the sequencer waits;
//    no beat is lost or repeated.
//  - Synchronous active-low reset clears the held-byte count, the offset
//    counter and the output valid; the counter also clears after tlast.
`timescale 1ns / 1ps
`default_nettype none

module utf8_decoder_with_utf16_count (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  wire         i_s_axis_tlast,   // is_last
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [20:0] scalar, [23:21] byte_count, [25:24] utf16_units,
    // [57:26] unit_offset, [63:58] zero
    output logic [63:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [0] is_trim_space, [1] run_last
    output logic        o_m_axis_tlast    // string_end
);
    import u8d_pkg::*;

    t_cmd             w_cmd;
    t_status          w_status;
    logic [CP_W-1:0]  w_scalar;
    logic [2:0]       w_byte_count;
    logic [1:0]       w_utf16_units;
    logic [31:0]      w_unit_offset;
    logic             w_trim_space;
    logic             w_run_last;
    logic             w_string_end;

    u8d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    u8d_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (i_s_axis_tdata),
        .i_last        (i_s_axis_tlast),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_scalar      (w_scalar),
        .o_byte_count  (w_byte_count),
        .o_utf16_units (w_utf16_units),
        .o_unit_offset (w_unit_offset),
        .o_trim_space  (w_trim_space),
        .o_run_last    (w_run_last),
        .o_string_end  (w_string_end)
    );

    assign o_m_axis_tdata = {6'd0, w_unit_offset, w_utf16_units, w_byte_count, w_scalar};
    assign o_m_axis_tuser = {w_run_last, w_trim_space};
    assign o_m_axis_tlast = w_string_end;

`ifndef ASSERT_OFF
    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result issued over an untaken output beat");

    a_no_load_and_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && w_cmd.emit))
        else $error("byte load and result issue in the same cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while the previous byte is in work");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser[1])
        else $error("string end on a result that is not last of its byte");
`endif

endmodule

`default_nettype wire

// File: bench/utf8_stream_checker.sv
// Scoreboard for the UTF-8 decoder: watches both stream channels, predicts each
// result beat from the accepted byte beats and compares field by field.
// Standalone; no package or RTL dependencies.
`timescale 1ns / 1ps

module utf8_stream_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_in_last,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [63:0] i_out_data,   // [20:0] cp, [23:21] bytes, [25:24] units, [57:26] offset
    input  wire  [1:0]  i_out_user,   // [0] trim space, [1] last result of the byte
    input  wire         i_out_last,   // last result of the string
    output logic [31:0] o_mismatches,
    output logic [31:0] o_outstanding
);

    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  nbytes;
        logic [1:0]  units;
        logic [31:0] offset;
        logic        trim;
        logic        byte_done;
        logic        str_done;
    } scalar_t;

    scalar_t     expected_scalars[$];
    logic [7:0]  held[3];
    int          held_n;
    logic [31:0] units_before;
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    initial o_outstanding = '0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic in_trim_set(input logic [20:0] c);
        case (c)
            21'h09, 21'h0a, 21'h0b, 21'h0c, 21'h0d, 21'h20, 21'ha0, 21'h1680,
            21'h2028, 21'h2029, 21'h202f, 21'h205f, 21'h3000, 21'hfeff: return 1'b1;
            default: return c >= 21'h2000 && c <= 21'h200a;
        endcase
    endfunction

    // Runs one byte through the held window and queues every scalar it releases.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [7:0]  w[4];
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [20:0] cp;
        logic [1:0]  units;
        logic        ok;
        logic        waiting;
        int          n;
        int          need;
        int          avail;
        int          len;
        int          i;
        int          k;
        scalar_t     r;
        scalar_t     res[4];
        for (i = 0; i < 3; i++) w[i] = held[i];
        w[3] = 8'h00;
        n = held_n;
        w[n] = b;
        n++;
        k = 0;
        waiting = 1'b0;
        while (n > 0 && k < 4 && !waiting) begin
            lo   = 8'h80;
            hi   = 8'hbf;
            need = 1;
            if (w[0] >= 8'hc2 && w[0] <= 8'hdf) begin
                need = 2;
            end else if (w[0] == 8'he0) begin
                need = 3;
                lo   = 8'ha0;
            end else if (w[0] == 8'hed) begin
                need = 3;
                hi   = 8'h9f;
            end else if (w[0] >= 8'he1 && w[0] <= 8'hef) begin
                need = 3;
            end else if (w[0] == 8'hf0) begin
                need = 4;
                lo   = 8'h90;
            end else if (w[0] == 8'hf4) begin
                need = 4;
                hi   = 8'h8f;
            end else if (w[0] >= 8'hf1 && w[0] <= 8'hf3) begin
                need = 4;
            end
            avail = (n < need) ? n : need;
            ok = !(avail > 1 && (w[1] < lo || w[1] > hi));
            for (i = 2; i < 4; i++)
                if (i < avail && w[i][7:6] != 2'b10) ok = 1'b0;
            if (ok && n < need && !last) begin
                waiting = 1'b1;   // sequence still open, hold the bytes
            end else begin
                len = (ok && n >= need) ? need : 1;
                case (len)
                    2: cp = {10'd0, w[0][4:0], w[1][5:0]};
                    3: cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
                    4: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
                    default: cp = {13'd0, w[0]};
                endcase
                units       = (cp > 21'h00ffff) ? 2'd2 : 2'd1;
                r.cp        = cp;
                r.nbytes    = len[2:0];
                r.units     = units;
                r.offset    = units_before;
                r.trim      = in_trim_set(cp);
                r.byte_done = 1'b0;
                r.str_done  = 1'b0;
                res[k]      = r;
                if (units_before > 32'hffff_ffff - 32'(units)) units_before = 32'hffff_ffff;
                else units_before = units_before + 32'(units);
                for (i = 0; i < 4; i++)
                    if (i + len < n) w[i] = w[i + len];
                n = n - len;
                k++;
            end
        end
        if (last) begin
            held_n       = 0;
            units_before = '0;
        end else begin
            held_n = n;
            for (i = 0; i < 3; i++) held[i] = w[i];
        end
        for (i = 0; i < k; i++) begin
            r = res[i];
            if (i == k - 1) begin
                r.byte_done = 1'b1;
                r.str_done  = last;
            end
            expected_scalars.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : watch
        scalar_t want;
        if (!i_rst_n) begin
            expected_scalars.delete();
            held_n       = 0;
            units_before = '0;
            for (int i = 0; i < 3; i++) held[i] = 8'h00;
        end else begin
            if (i_in_valid && i_in_ready) decode_byte(i_in_byte, i_in_last);
            if (i_out_valid && i_out_ready) begin
                if (expected_scalars.size() == 0) begin
                    report_mismatch("result beat with nothing pending", i_out_data[31:0], 0);
                end else begin
                    want = expected_scalars.pop_front();
                    if (i_out_data[20:0] != want.cp)
                        report_mismatch("scalar", 32'(i_out_data[20:0]), 32'(want.cp));
                    if (i_out_data[23:21] != want.nbytes)
                        report_mismatch("byte_count", 32'(i_out_data[23:21]),
                                        32'(want.nbytes));
                    if (i_out_data[25:24] != want.units)
                        report_mismatch("utf16_units", 32'(i_out_data[25:24]),
                                        32'(want.units));
                    if (i_out_data[57:26] != want.offset)
                        report_mismatch("unit_offset", i_out_data[57:26], want.offset);
                    if (i_out_user[0] != want.trim)
                        report_mismatch("is_trim_space", 32'(i_out_user[0]), 32'(want.trim));
                    if (i_out_user[1] != want.byte_done)
                        report_mismatch("run_last", 32'(i_out_user[1]), 32'(want.byte_done));
                    if (i_out_last != want.str_done)
                        report_mismatch("string_end", 32'(i_out_last), 32'(want.str_done));
                end
            end
        end
        o_outstanding <= expected_scalars.size();
    end

endmodule

// File: bench/tb_utf8_decoder_with_utf16_count.sv
// Testbench top for utf8_decoder_with_utf16_count: drives byte strings with
// random gaps and back-pressure; checking is done by utf8_stream_checker.
`timescale 1ns / 1ps

module tb_utf8_decoder_with_utf16_count;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_STALL   = 80;
    localparam int PHASE_BYTES  = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = 8'h00;
    logic        in_last   = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_data;
    logic [1:0]  out_user;
    logic        out_last;
    logic [31:0] mismatches;
    logic [31:0] outstanding;

    logic        stall_go   = 1'b0;
    int          stall_left = 0;
    int          send_idle_pct = 0;
    int          rcv_idle_pct  = 0;
    int          cycles = 0;

    logic [7:0]  str_q[$];   // string being built
    logic [8:0]  tx_q[$];    // {last, byte} beats ready to send

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utf8_decoder_with_utf16_count dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_byte),
        .i_s_axis_tlast  (in_last),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user),
        .o_m_axis_tlast  (out_last)
    );

    utf8_stream_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .i_in_last     (in_last),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_out_user    (out_user),
        .i_out_last    (out_last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_go) begin
            out_ready  <= 1'b0;
            stall_left <= LONG_STALL;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic put(input logic [7:0] b);
        str_q.push_back(b);
    endtask

    task automatic put_cont();
        put(8'($urandom_range(8'h80, 8'hbf)));
    endtask

    // closes the string: tlast goes on its final byte
    task automatic commit_string();
        for (int i = 0; i < str_q.size(); i++)
            tx_q.push_back({i == str_q.size() - 1, str_q[i]});
        str_q.delete();
    endtask

    task automatic add_char();
        int         kind;
        logic [7:0] lead;
        kind = $urandom_range(0, 13);
        case (kind)
            0, 1: put(8'($urandom_range(0, 8'h7f)));
            2: begin
                case ($urandom_range(0, 5))
                    0: put(8'h09);
                    1: put(8'h0a);
                    2: put(8'h0b);
                    3: put(8'h0c);
                    4: put(8'h0d);
                    default: put(8'h20);
                endcase
            end
            3: begin
                case ($urandom_range(0, 6))
                    0: begin put(8'hc2); put(8'ha0); end
                    1: begin put(8'he1); put(8'h9a); put(8'h80); end
                    2: begin put(8'he2); put(8'h80); put(8'($urandom_range(8'h80, 8'h8a))); end
                    3: begin put(8'he2); put(8'h80); put(8'($urandom_range(8'ha8, 8'haf))); end
                    4: begin put(8'he2); put(8'h81); put(8'h9f); end
                    5: begin put(8'he3); put(8'h80); put(8'h80); end
                    default: begin put(8'hef); put(8'hbb); put(8'hbf); end
                endcase
            end
            4: begin put(8'($urandom_range(8'hc2, 8'hdf))); put_cont(); end
            5: begin put(8'he0); put(8'($urandom_range(8'ha0, 8'hbf))); put_cont(); end
            6: begin
                lead = 8'($urandom_range(8'he1, 8'hef));
                if (lead == 8'hed) lead = 8'hee;
                put(lead); put_cont(); put_cont();
            end
            7: begin put(8'hed); put(8'($urandom_range(8'h80, 8'h9f))); put_cont(); end
            8: begin
                put(8'hf0); put(8'($urandom_range(8'h90, 8'hbf))); put_cont(); put_cont();
            end
            9: begin
                put(8'($urandom_range(8'hf1, 8'hf3))); put_cont(); put_cont(); put_cont();
            end
            10: begin
                put(8'hf4); put(8'($urandom_range(8'h80, 8'h8f))); put_cont(); put_cont();
            end
            11: put(8'($urandom_range(0, 255)));
            12: begin
                // second byte just outside the range its lead allows
                case ($urandom_range(0, 3))
                    0: begin put(8'he0); put(8'($urandom_range(8'h80, 8'h9f))); end
                    1: begin put(8'hed); put(8'($urandom_range(8'ha0, 8'hbf))); end
                    2: begin put(8'hf0); put(8'($urandom_range(8'h80, 8'h8f))); end
                    default: begin put(8'hf4); put(8'($urandom_range(8'h90, 8'hbf))); end
                endcase
                put_cont();
            end
            default: begin
                // lead with at most one follower, mostly a cut-short sequence; at string end it gets flushed raw
                put(8'($urandom_range(8'hc2, 8'hf4)));
                if ($urandom_range(0, 1)) put_cont();
            end
        endcase
    endtask

    task automatic send_all();
        logic [8:0] beat;
        while (tx_q.size() != 0) begin
            beat = tx_q.pop_front();
            while ($urandom_range(0, 99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= beat[7:0];
            in_last  <= beat[8];
            @(posedge clk);
            while (!in_ready) @(posedge clk);
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        rcv_idle_pct  = 78;
        // ASCII extremes, space, stray A0, NBSP, tightest E0/ED/F4 forms, max scalar
        put(8'h00); put(8'h7f); put(8'h20); put(8'ha0);
        put(8'hc2); put(8'ha0);
        put(8'he0); put(8'ha0); put(8'h80);
        put(8'hed); put(8'h9f); put(8'hbf);
        put(8'hf4); put(8'h8f); put(8'hbf); put(8'hbf);
        // three held bytes broken by ASCII: four results from one beat
        put(8'hf1); put(8'h80); put(8'h80); put(8'h41);
        // invalid leads, bad follower, then a truncated sequence at the end
        put(8'hc1); put(8'hff);
        put(8'hf0); put(8'h8f);
        put(8'he2); put(8'h80);
        commit_string();
        send_all();
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 26; rcv_idle_pct = 78; end
                1: begin send_idle_pct = 78; rcv_idle_pct = 26; end
                default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            while (tx_q.size() < PHASE_BYTES) begin
                repeat ($urandom_range(1, 8)) add_char();
                commit_string();
            end
            if (phase == 2) begin
                // receiver holds off while bytes keep coming, so the input backs up
                stall_go <= 1'b1;
                @(posedge clk);
                stall_go <= 1'b0;
            end
            send_all();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("utf8_decoder_with_utf16_count verification clean");
        end else begin
            $display("utf8_decoder_with_utf16_count verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("utf8_decoder_with_utf16_count verification failed");
        $finish;
    end

endmodule
